[rtl/ffba_pkg.sv]
// Shared types, widths and defaults for the first-fit block allocator.
`default_nettype none

package ffba_pkg;

    // Item fields
    localparam int LEN_W     = 32;
    localparam int FSTART_W  = 10;
    localparam int FCOUNT_W  = 11;
    localparam int START_W   = 10;
    localparam int COUNT_W   = 11;
    localparam int S_TDATA_W = 56;  // 53 field bits padded to whole bytes
    localparam int M_TDATA_W = 24;  // 21 field bits padded to whole bytes

    // Map word organization
    localparam int WORD_W = 32;
    localparam int BIT_W  = 5;

    // Run lengths up to the largest supported map plus one word
    localparam int RUN_W = 17;

    // Rounded-up byte length and divider step count
    localparam int NUM_W     = LEN_W + 1;
    localparam int DIV_CNT_W = 6;

    localparam int DEF_BLOCK_COUNT = 1024;
    localparam int DEF_BLOCK_BYTES = 1024;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_CHECK,
        ST_SCAN,
        ST_MRD,
        ST_MARK,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic               hit;
        logic [BIT_W-1:0]   hit_bit;
        logic [RUN_W-1:0]   run;
    } t_scan_res;

endpackage

`default_nettype wire

[rtl/ffba_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ffba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[rtl/ffba_scan.sv]
// One-word step of the free-run search: run ending at each bit, first hit.
`default_nettype none

module ffba_scan
    import ffba_pkg::*;
(
    input  wire logic [WORD_W-1:0] i_used,   // 1 = used or past map end
    input  wire logic [RUN_W-1:0]  i_carry,  // free run ending below bit 0
    input  wire logic [RUN_W-1:0]  i_need,
    output t_scan_res              o_res
);

    always_comb begin : p_scan
        logic             found;
        logic [BIT_W-1:0] pos;
        logic [RUN_W-1:0] run;
        o_res = '0;
        // downward so the lowest hitting bit wins
        for (int j = WORD_W - 1; j >= 0; j--) begin
            found = 1'b0;
            pos   = '0;
            for (int k = 0; k <= j; k++) begin
                if (i_used[k]) begin
                    found = 1'b1;
                    pos   = BIT_W'(k);
                end
            end
            run = found ? RUN_W'(BIT_W'(j) - pos) : i_carry + RUN_W'(j + 1);
            if (j == WORD_W - 1) begin
                o_res.run = run;
            end
            if (run >= i_need) begin
                o_res.hit     = 1'b1;
                o_res.hit_bit = BIT_W'(j);
            end
        end
    end

endmodule

`default_nettype wire

[rtl/first_fit_block_allocator_core.sv]
// First-fit contiguous block allocator over a word-wide occupancy map in RAM.
//
//  channel   | dir | tdata (low bit up)                     | tuser
//  s_axis    | in  | byte_length, free_start, free_count    | operation
//  m_axis    | out | start_block, block_count               | status
//
// One item at a time. Allocate: accept, a reciprocal multiply over the low and
// high constant halves unless BLOCK_BYTES is a power of two, check, a scan of the
// map (one map word per cycle through the RAM read port), then a RAM read and a
// read-modify-write of each spanned word for the marking pass, response. Free:
// accept, check, marking pass, response. After reset the map RAM is cleared one
// word per cycle with s_axis_tready low. A new item is taken while a result waits
// on m_axis; the block holds at its response step only if the previous result is
// still there.
`default_nettype none

module first_fit_block_allocator_core
    import ffba_pkg::*;
#(
    parameter int BLOCK_COUNT = DEF_BLOCK_COUNT,
    parameter int BLOCK_BYTES = DEF_BLOCK_BYTES
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,  // byte_length, free_start, free_count
    input  wire logic                 s_axis_tuser,  // operation
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic      [M_TDATA_W-1:0] m_axis_tdata,  // start_block, block_count
    output logic                      m_axis_tuser   // status
);

    localparam int NWORDS = (BLOCK_COUNT + WORD_W - 1) / WORD_W;
    localparam int WA_W   = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int GI_W   = WA_W + BIT_W;
    localparam int SUM_W  = (GI_W + 1 > FCOUNT_W + 1) ? GI_W + 1 : FCOUNT_W + 1;
    localparam int LOG2_BB = $clog2(BLOCK_BYTES);
    localparam bit BB_POW2 = ((BLOCK_BYTES & (BLOCK_BYTES - 1)) == 0);
    localparam int DIV_STEPS = 2;

    // ceil(2^(NUM_W+LOG2_BB) / BLOCK_BYTES), exact quotient for any NUM_W-bit dividend
    localparam int MUL_W     = 17;
    localparam int PROD_W    = NUM_W + 2 * MUL_W;
    localparam int RECIP_SH  = NUM_W + LOG2_BB;
    localparam logic [63:0] RECIP =
        ((64'd1 << RECIP_SH) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES);
    localparam logic [MUL_W-1:0] RECIP_LO = RECIP[MUL_W-1:0];
    localparam logic [MUL_W-1:0] RECIP_HI = RECIP[2*MUL_W-1:MUL_W];

    localparam logic [WA_W-1:0]  LAST_WORD = WA_W'(NWORDS - 1);
    localparam logic [SUM_W-1:0] BC_S      = SUM_W'(BLOCK_COUNT);
    localparam logic [GI_W:0]    BC_G      = (GI_W + 1)'(BLOCK_COUNT);
    localparam logic [NUM_W-1:0] BC_Q      = NUM_W'(BLOCK_COUNT);

    t_state r_state, n_state;

    logic                 r_op, n_op;
    logic [NUM_W-1:0]     r_num, n_num;
    logic [PROD_W-1:0]    r_prod, n_prod;
    logic [DIV_CNT_W-1:0] r_div_cnt, n_div_cnt;
    logic [FSTART_W-1:0]  r_fstart, n_fstart;
    logic [FCOUNT_W-1:0]  r_fcount, n_fcount;
    logic [RUN_W-1:0]     r_need, n_need;
    logic [RUN_W-1:0]     r_carry, n_carry;
    logic [WA_W-1:0]      r_word, n_word;
    logic [GI_W-1:0]      r_lo, n_lo;
    logic [GI_W-1:0]      r_hi, n_hi;
    logic                 r_res_status, n_res_status;
    logic [START_W-1:0]   r_res_start, n_res_start;
    logic [COUNT_W-1:0]   r_res_count, n_res_count;
    logic                 r_m_tvalid, n_m_tvalid;
    logic                 r_m_status, n_m_status;
    logic [START_W-1:0]   r_m_start, n_m_start;
    logic [COUNT_W-1:0]   r_m_count, n_m_count;

    logic                 ram_we;
    logic [WA_W-1:0]      ram_waddr;
    logic [WORD_W-1:0]    ram_wdata;
    logic [WA_W-1:0]      ram_raddr;
    logic [WORD_W-1:0]    ram_rdata;

    logic [WORD_W-1:0]    scan_used;
    logic [WORD_W-1:0]    mark_mask;
    t_scan_res            scan_res;

    logic                 accept;
    logic [NUM_W-1:0]     quot;
    logic [MUL_W-1:0]     mul_k;
    logic [NUM_W+MUL_W-1:0] mul_p;
    logic [SUM_W-1:0]     f_end;
    logic                 f_none;
    logic [GI_W-1:0]      hit_end;
    logic [GI_W-1:0]      hit_lo;
    logic [WA_W-1:0]      hi_word;
    logic                 out_free;

    ffba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NWORDS),
        .AW    (WA_W)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    ffba_scan u_scan (
        .i_used  (scan_used),
        .i_carry (r_carry),
        .i_need  (r_need),
        .o_res   (scan_res)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_m_tvalid || m_axis_tready;

    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tuser  = r_m_status;
    assign m_axis_tdata  = {{(M_TDATA_W - START_W - COUNT_W){1'b0}}, r_m_count, r_m_start};

    // rounded-up block count
    assign quot = BB_POW2 ? (r_num >> LOG2_BB) : NUM_W'(r_prod >> RECIP_SH);

    // reciprocal product, low constant half first, high half second
    assign mul_k = (r_div_cnt == '0) ? RECIP_LO : RECIP_HI;
    assign mul_p = (NUM_W + MUL_W)'(r_num) * (NUM_W + MUL_W)'(mul_k);

    // free range, clipped to the map end
    assign f_end  = SUM_W'(r_fstart) + SUM_W'(r_fcount) - SUM_W'(1);
    assign f_none = (r_fcount == '0) || (SUM_W'(r_fstart) >= BC_S);

    assign hit_end = {r_word, scan_res.hit_bit};
    assign hit_lo  = hit_end - GI_W'(r_need) + GI_W'(1);
    assign hi_word = r_hi[GI_W-1:BIT_W];

    // map bits past the last block read as used; mark mask covers [lo, hi]
    always_comb begin
        logic [GI_W-1:0] gidx;
        for (int b = 0; b < WORD_W; b++) begin
            gidx         = {r_word, BIT_W'(b)};
            scan_used[b] = ram_rdata[b] || ({1'b0, gidx} >= BC_G);
            mark_mask[b] = (gidx >= r_lo) && (gidx <= r_hi);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_word == LAST_WORD) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) begin
                    if (s_axis_tuser || BB_POW2) n_state = ST_CHECK;
                    else                         n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (r_op) begin
                    n_state = f_none ? ST_RESP : ST_MRD;
                end else if (quot == '0 || quot > BC_Q) begin
                    n_state = ST_RESP;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_res.hit)            n_state = ST_MRD;
                else if (r_word == LAST_WORD) n_state = ST_RESP;
            end
            ST_MRD: begin
                n_state = ST_MARK;
            end
            ST_MARK: begin
                if (r_word == hi_word) n_state = ST_RESP;
            end
            ST_RESP: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // datapath and RAM control
    always_comb begin
        n_op         = r_op;
        n_num        = r_num;
        n_prod       = r_prod;
        n_div_cnt    = r_div_cnt;
        n_fstart     = r_fstart;
        n_fcount     = r_fcount;
        n_need       = r_need;
        n_carry      = r_carry;
        n_word       = r_word;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_res_status = r_res_status;
        n_res_start  = r_res_start;
        n_res_count  = r_res_count;
        n_m_tvalid   = r_m_tvalid && !m_axis_tready;
        n_m_status   = r_m_status;
        n_m_start    = r_m_start;
        n_m_count    = r_m_count;
        ram_we       = 1'b0;
        ram_waddr    = r_word;
        ram_wdata    = '0;
        ram_raddr    = '0;

        case (r_state)
            ST_CLEAR: begin
                ram_we = 1'b1;
                n_word = r_word + WA_W'(1);
            end
            ST_IDLE: begin
                if (accept) begin
                    n_op         = s_axis_tuser;
                    n_num        = NUM_W'(s_axis_tdata[LEN_W-1:0]) + NUM_W'(BLOCK_BYTES - 1);
                    n_div_cnt    = '0;
                    n_fstart     = s_axis_tdata[LEN_W +: FSTART_W];
                    n_fcount     = s_axis_tdata[LEN_W + FSTART_W +: FCOUNT_W];
                    n_res_status = 1'b0;
                    n_res_start  = '0;
                    n_res_count  = '0;
                end
            end
            ST_DIV: begin
                if (r_div_cnt == '0) n_prod = PROD_W'(mul_p);
                else                 n_prod = r_prod + {mul_p, MUL_W'(0)};
                n_div_cnt = r_div_cnt + DIV_CNT_W'(1);
            end
            ST_CHECK: begin
                if (r_op) begin
                    n_lo = GI_W'(r_fstart);
                    n_hi = (f_end >= BC_S) ? GI_W'(BLOCK_COUNT - 1) : GI_W'(f_end);
                end else if (quot > BC_Q) begin
                    n_res_status = 1'b1;
                end else begin
                    n_need    = RUN_W'(quot);
                    n_carry   = '0;
                    n_word    = '0;
                    ram_raddr = '0;
                end
            end
            ST_SCAN: begin
                ram_raddr = (r_word == LAST_WORD) ? r_word : r_word + WA_W'(1);
                n_word    = r_word + WA_W'(1);
                n_carry   = scan_res.run;
                if (scan_res.hit) begin
                    n_lo        = hit_lo;
                    n_hi        = hit_end;
                    n_res_start = START_W'(hit_lo);
                    n_res_count = COUNT_W'(r_need);
                end else if (r_word == LAST_WORD) begin
                    n_res_status = 1'b1;
                end
            end
            ST_MRD: begin
                ram_raddr = r_lo[GI_W-1:BIT_W];
                n_word    = r_lo[GI_W-1:BIT_W];
            end
            ST_MARK: begin
                ram_we    = 1'b1;
                ram_wdata = r_op ? (ram_rdata & ~mark_mask) : (ram_rdata | mark_mask);
                ram_raddr = (r_word == hi_word) ? r_word : r_word + WA_W'(1);
                n_word    = r_word + WA_W'(1);
            end
            ST_RESP: begin
                if (out_free) begin
                    n_m_tvalid = 1'b1;
                    n_m_status = r_res_status;
                    n_m_start  = r_res_start;
                    n_m_count  = r_res_count;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_word     <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_word     <= n_word;
            r_m_tvalid <= n_m_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_num        <= n_num;
        r_prod       <= n_prod;
        r_div_cnt    <= n_div_cnt;
        r_fstart     <= n_fstart;
        r_fcount     <= n_fcount;
        r_need       <= n_need;
        r_carry      <= n_carry;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_res_status <= n_res_status;
        r_res_start  <= n_res_start;
        r_res_count  <= n_res_count;
        r_m_status   <= n_m_status;
        r_m_start    <= n_m_start;
        r_m_count    <= n_m_count;
    end

endmodule

`default_nettype wire

[dv/testbench.sv]
// Self-checking stream testbench for the first-fit block allocator core.
module testbench;
    import ffba_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NBLK      = DEF_BLOCK_COUNT;
    localparam int BLK_BYTES = DEF_BLOCK_BYTES;
    localparam int IDLE_PCT  = 28;
    localparam int RANDOM_ITEMS = 1030;
    localparam int HOLD_AT     = 800;
    localparam int HOLD_CYCLES = 400;

    localparam logic OP_ALLOC     = 1'b0;
    localparam logic OP_FREE      = 1'b1;
    localparam logic RES_OK       = 1'b0;
    localparam logic RES_NO_SPACE = 1'b1;

    typedef struct {
        logic                status;
        logic [START_W-1:0]  start;
        logic [COUNT_W-1:0]  count;
    } t_grant;

    // Shadow occupancy map plus the queue of results still owed by the block.
    class t_scoreboard;
        bit          busy_map [NBLK];
        t_grant      grants_due [$];
        int          live_start [$];
        int          live_count [$];
        int          errors;
        int          granted;
        int          refused;
        int          frees;

        function new();
            foreach (busy_map[i]) busy_map[i] = 1'b0;
            errors  = 0;
            granted = 0;
            refused = 0;
            frees   = 0;
        endfunction

        function void note_request(logic op, logic [LEN_W-1:0] len,
                                   logic [FSTART_W-1:0] fs, logic [FCOUNT_W-1:0] fc);
            t_grant           g;
            longint unsigned  l64;
            longint unsigned  need;
            int               run;
            int               first;
            int               b;
            g.status = RES_OK;
            g.start  = '0;
            g.count  = '0;
            if (op == OP_FREE) begin
                for (int i = 0; i < int'(fc); i++) begin
                    b = int'(fs) + i;
                    if (b < NBLK) busy_map[b] = 1'b0;
                end
                frees++;
            end else begin
                l64  = len;
                need = (l64 + BLK_BYTES - 1) / BLK_BYTES;
                if (need > NBLK) begin
                    g.status = RES_NO_SPACE;
                    refused++;
                end else if (need != 0) begin
                    run   = 0;
                    first = 0;
                    for (int i = 0; i < NBLK && run < need; i++) begin
                        if (!busy_map[i]) begin
                            if (run == 0) first = i;
                            run++;
                        end else begin
                            run = 0;
                        end
                    end
                    if (run < need) begin
                        g.status = RES_NO_SPACE;
                        refused++;
                    end else begin
                        for (int i = first; i < first + int'(need); i++) busy_map[i] = 1'b1;
                        g.start = first[START_W-1:0];
                        g.count = need[COUNT_W-1:0];
                        live_start = {live_start, first};
                        live_count = {live_count, int'(need)};
                        granted++;
                    end
                end
            end
            grants_due = {grants_due, g};
        endfunction

        function void check_grant(logic st, logic [START_W-1:0] sb, logic [COUNT_W-1:0] bc);
            t_grant e;
            if (grants_due.size() == 0) begin
                $error("unexpected result: status %0d start_block %0d block_count %0d",
                       st, sb, bc);
                errors++;
                return;
            end
            e = grants_due.pop_front();
            if (st !== e.status) begin
                $error("status: expected %0d, actual %0d", e.status, st);
                errors++;
            end
            if (sb !== e.start) begin
                $error("start_block: expected %0d, actual %0d", e.start, sb);
                errors++;
            end
            if (bc !== e.count) begin
                $error("block_count: expected %0d, actual %0d", e.count, bc);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata;   // byte_length, free_start, free_count
    logic                  s_axis_tuser;   // operation
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;   // start_block, block_count
    logic                  m_axis_tuser;   // status

    t_scoreboard           ledger;
    int                    items_sent;
    bit                    calm;

    first_fit_block_allocator_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    task automatic send_item(input logic op, input logic [LEN_W-1:0] len,
                             input logic [FSTART_W-1:0] fs, input logic [FCOUNT_W-1:0] fc);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= S_TDATA_W'({fc, fs, len});
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        ledger.note_request(op, len, fs, fc);
        items_sent++;
        calm = (items_sent >= 300 && items_sent < 500);
    endtask

    task automatic alloc(input logic [LEN_W-1:0] len);
        send_item(OP_ALLOC, len, FSTART_W'($urandom_range(NBLK - 1)),
                  FCOUNT_W'($urandom_range(NBLK)));
    endtask

    task automatic release_run(input int start, input int count);
        send_item(OP_FREE, $urandom, FSTART_W'(start), FCOUNT_W'(count));
    endtask

    task automatic random_item();
        int r;
        int blocks;
        int idx;
        logic [LEN_W-1:0] len;
        r = $urandom_range(99);
        if (ledger.live_start.size() > 50 && r < 60) r = 60 + $urandom_range(29);
        if (r < 45) begin
            blocks = $urandom_range(1, 16);
            len = blocks * BLK_BYTES;
            if ($urandom_range(1)) len = len - $urandom_range(BLK_BYTES - 1);
            alloc(len);
        end else if (r < 55) begin
            alloc($urandom_range(1, 256 * BLK_BYTES));
        end else if (r < 60) begin
            case ($urandom_range(3))
                0: alloc('0);
                1: alloc($urandom);
                2: alloc(NBLK * BLK_BYTES - $urandom_range(BLK_BYTES));
                default: alloc(NBLK * BLK_BYTES + $urandom_range(1, BLK_BYTES));
            endcase
        end else if (r < 90 && ledger.live_start.size() != 0) begin
            // well-formed: give back a run that was granted earlier
            idx = $urandom_range(ledger.live_start.size() - 1);
            release_run(ledger.live_start[idx], ledger.live_count[idx]);
            ledger.live_start.delete(idx);
            ledger.live_count.delete(idx);
        end else begin
            release_run($urandom_range(NBLK - 1),
                        ($urandom_range(9) == 0) ? NBLK : $urandom_range(NBLK));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            ledger.check_grant(m_axis_tuser, m_axis_tdata[START_W-1:0],
                               m_axis_tdata[START_W +: COUNT_W]);
        end
    end

    // Receiver: random stalls, one long hold-off to back the block up.
    initial begin : receiver
        int hold_left;
        bit held;
        hold_left = 0;
        held = 1'b0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && items_sent >= HOLD_AT) begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial begin : watchdog
        #10_000_000;
        $display("testbench: errors");
        $finish;
    end

    initial begin : stimulus
        ledger = new();
        items_sent = 0;
        calm = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_ALLOC;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        alloc(0);                          // zero length, map empty
        alloc(1);
        alloc(BLK_BYTES);
        alloc(BLK_BYTES + 1);              // rounds up to two blocks
        alloc(NBLK * BLK_BYTES + 1);       // larger than the map
        send_item(OP_ALLOC, '1, '1, FCOUNT_W'(NBLK));
        alloc(NBLK * BLK_BYTES);           // whole map, but some is taken
        send_item(OP_FREE, '1, '0, FCOUNT_W'(NBLK));
        alloc(NBLK * BLK_BYTES);           // whole map fits now
        alloc(1);                          // map full
        alloc(0);                          // zero length still succeeds
        release_run(NBLK - 4, 10);         // runs past the map end
        alloc(4 * BLK_BYTES);
        release_run(NBLK - 1, NBLK);
        release_run(NBLK - 1, NBLK);       // already free
        alloc(1);
        release_run(100, 0);
        release_run(0, NBLK);
        alloc(33 * BLK_BYTES);             // crosses a map word
        alloc(31 * BLK_BYTES + 1);
        release_run(10, 5);
        alloc(6 * BLK_BYTES);              // hole too small, goes past it
        alloc(5 * BLK_BYTES);              // fills the hole exactly
        release_run(0, NBLK);
        ledger.live_start.delete();
        ledger.live_count.delete();

        repeat (RANDOM_ITEMS) random_item();

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (ledger.grants_due.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        $display("summary: %0d items, %0d allocations granted, %0d refused, %0d frees",
                 items_sent, ledger.granted, ledger.refused, ledger.frees);
        $display("summary: random stalls on both sides plus a %0d-cycle output hold-off",
                 HOLD_CYCLES);
        if (ledger.errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end
endmodule
